### rtl/core/ps2mt_pkg.sv
package ps2mt_pkg;

  // coordinate width of the tracked position
  localparam int COORD_BITS = 12;
  localparam int SUM_W      = COORD_BITS + 2;
  localparam int LIM_W      = (COORD_BITS > 12) ? COORD_BITS : 12;

  // fixed field widths
  localparam int BYTE_W = 8;
  localparam int POS_W  = 12;
  localparam int BTN_W  = 3;
  localparam int CFG_W  = 12;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [COORD_BITS-1:0] COORD_MASK = {COORD_BITS{1'b1}};
  localparam logic [COORD_BITS-1:0] START_POS  = COORD_BITS'(20);
  localparam logic [CFG_W-1:0]      MAX_X_RST  = CFG_W'(639);
  localparam logic [CFG_W-1:0]      MAX_Y_RST  = CFG_W'(479);

  // header bit positions
  localparam int SYNC_BIT   = 3;
  localparam int X_SIGN_BIT = 4;
  localparam int Y_SIGN_BIT = 5;
  localparam int X_OVF_BIT  = 6;
  localparam int Y_OVF_BIT  = 7;

  // register index codes (address bit 2)
  localparam logic REG_MAX_X = 1'b0;
  localparam logic REG_MAX_Y = 1'b1;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DX     = 2'd1,
    PH_DY     = 2'd2
  } phase_t;

  typedef struct packed {
    logic [CFG_W-1:0] max_x;
    logic [CFG_W-1:0] max_y;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] rx_byte;
  } stage_t;

  typedef struct packed {
    logic   fire;
    phase_t phase;
  } core_stat_t;

  // clamp limit: max register saturated to the coordinate range
  function automatic logic [COORD_BITS-1:0] coord_lim(input logic [CFG_W-1:0] m);
    logic [LIM_W-1:0] ext;
    ext = LIM_W'(m);
    if (ext > LIM_W'(COORD_MASK)) return COORD_MASK;
    return COORD_BITS'(ext);
  endfunction

  // clamp a signed sum to 0..lim
  function automatic logic [COORD_BITS-1:0] clamp_coord(
    input logic signed [SUM_W-1:0] v,
    input logic [COORD_BITS-1:0]   lim
  );
    logic signed [SUM_W-1:0] lim_s;
    lim_s = $signed({2'b00, lim});
    if (v < 0) return '0;
    if (v > lim_s) return lim;
    return COORD_BITS'(v);
  endfunction

endpackage

### rtl/core/ps2mt_in_if.sv
interface ps2mt_in_if;
  import ps2mt_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

### rtl/core/ps2mt_out_if.sv
interface ps2mt_out_if;
  import ps2mt_pkg::*;

  logic             valid;
  logic             ready;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  logic [BTN_W-1:0] button_bits;

  modport source (output valid, output pos_x, output pos_y, output button_bits, input ready);
  modport sink (input valid, input pos_x, input pos_y, input button_bits, output ready);
endinterface

### rtl/core/ps2_mouse_packet_tracker_unit.sv
// path: an accepted byte passes the input register, then a dy byte loads the result
//   register; results follow the third byte only, and only if no overflow bit is set
// throughput: one byte per cycle while the result register is free or being taken
// reset: rst_n synchronous active low; phase 0, buttons cleared,
//   position 20/20, max_x 639, max_y 479, no result pending
module ps2_mouse_packet_tracker_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  ps2mt_in_if.sink                     in_ch,
  ps2mt_out_if.source                  out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ps2mt_pkg::ADDR_W-1:0] paddr,
  input  logic [ps2mt_pkg::DATA_W-1:0] pwdata,
  output logic [ps2mt_pkg::DATA_W-1:0] prdata,
  output logic                         pready
);
  import ps2mt_pkg::*;

  cfg_t       cfg;
  stage_t     stg;
  core_stat_t stat;
  logic       adv;

  ps2mt_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ps2mt_in_stage u_in (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .adv   (adv),
    .stg   (stg)
  );

  ps2mt_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .stg    (stg),
    .cfg    (cfg),
    .adv    (adv),
    .stat   (stat),
    .out_ch (out_ch)
  );

  // a new word appears only after a dy byte was processed
  a_out_after_dy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(stat.fire && stat.phase == PH_DY))
    else $error("result without dy byte");

  // header without sync bit keeps the tracker in phase 0
  a_sync_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.fire && stat.phase == PH_HEADER && !stg.rx_byte[SYNC_BIT])
      |=> stat.phase == PH_HEADER)
    else $error("unsynced header advanced phase");

  // an empty input register never blocks the input
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !stg.valid |-> in_ch.ready)
    else $error("input stalled while empty");
endmodule

### rtl/core/ps2mt_cfg_regs.sv
module ps2mt_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ps2mt_pkg::ADDR_W-1:0] paddr,
  input  logic [ps2mt_pkg::DATA_W-1:0] pwdata,
  output logic [ps2mt_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output ps2mt_pkg::cfg_t            cfg
);
  import ps2mt_pkg::*;

  logic [CFG_W-1:0] max_x_r, max_x_nxt;
  logic [CFG_W-1:0] max_y_r, max_y_nxt;
  logic             wr_en;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  // register write decode
  always_comb begin
    max_x_nxt = max_x_r;
    max_y_nxt = max_y_r;
    if (wr_en) begin
      if (reg_sel == REG_MAX_X) max_x_nxt = pwdata[CFG_W-1:0];
      if (reg_sel == REG_MAX_Y) max_y_nxt = pwdata[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_x_r <= MAX_X_RST;
      max_y_r <= MAX_Y_RST;
    end else begin
      max_x_r <= max_x_nxt;
      max_y_r <= max_y_nxt;
    end
  end

  // read mux
  assign prdata = (reg_sel == REG_MAX_Y) ? DATA_W'(max_y_r) : DATA_W'(max_x_r);

  assign cfg.max_x = max_x_r;
  assign cfg.max_y = max_y_r;
endmodule

### rtl/core/ps2mt_in_stage.sv
module ps2mt_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  ps2mt_in_if.sink             in_ch,
  input  logic                 adv,
  output ps2mt_pkg::stage_t    stg
);
  import ps2mt_pkg::*;

  logic              valid_r, valid_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              take;

  // stage is free when empty or draining this cycle
  assign in_ch.ready = !valid_r || adv;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = take ? 1'b1 : (valid_r && !adv);
    byte_nxt  = take ? in_ch.rx_byte : byte_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign stg.valid   = valid_r;
  assign stg.rx_byte = byte_r;
endmodule

### rtl/core/ps2mt_core.sv
module ps2mt_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ps2mt_pkg::stage_t     stg,
  input  ps2mt_pkg::cfg_t       cfg,
  output logic                  adv,
  output ps2mt_pkg::core_stat_t stat,
  ps2mt_out_if.source           out_ch
);
  import ps2mt_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic [BTN_W-1:0]       btn_r, btn_nxt;
  logic [BYTE_W-1:0]      hdr_r, hdr_nxt;
  logic [BYTE_W-1:0]      dx_r, dx_nxt;
  logic [COORD_BITS-1:0]  x_r, x_nxt;
  logic [COORD_BITS-1:0]  y_r, y_nxt;
  logic                   ov_r, ov_nxt;
  logic [POS_W-1:0]       px_r, px_nxt;
  logic [POS_W-1:0]       py_r, py_nxt;
  logic [BTN_W-1:0]       pb_r, pb_nxt;
  logic                   fire;
  logic signed [SUM_W-1:0] nx, ny;
  logic [COORD_BITS-1:0]  cx, cy;

  // advance when the result register is free or being taken
  assign adv  = !ov_r || out_ch.ready;
  assign fire = stg.valid && adv;

  // 9-bit deltas, x adds, y subtracts
  assign nx = $signed({2'b00, x_r}) + SUM_W'($signed({hdr_r[X_SIGN_BIT], dx_r}));
  assign ny = $signed({2'b00, y_r}) - SUM_W'($signed({hdr_r[Y_SIGN_BIT], stg.rx_byte}));
  assign cx = clamp_coord(nx, coord_lim(cfg.max_x));
  assign cy = clamp_coord(ny, coord_lim(cfg.max_y));

  // packet phase sequencing and result load
  always_comb begin
    phase_nxt = phase_r;
    btn_nxt   = btn_r;
    hdr_nxt   = hdr_r;
    dx_nxt    = dx_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    ov_nxt    = ov_r && !out_ch.ready;
    px_nxt    = px_r;
    py_nxt    = py_r;
    pb_nxt    = pb_r;
    if (fire) begin
      unique case (phase_r)
        PH_HEADER: begin
          hdr_nxt = stg.rx_byte;
          if (stg.rx_byte[SYNC_BIT]) begin
            btn_nxt   = stg.rx_byte[BTN_W-1:0];
            phase_nxt = PH_DX;
          end
        end
        PH_DX: begin
          dx_nxt    = stg.rx_byte;
          phase_nxt = PH_DY;
        end
        PH_DY: begin
          phase_nxt = PH_HEADER;
          if (!(hdr_r[X_OVF_BIT] || hdr_r[Y_OVF_BIT])) begin
            x_nxt  = cx;
            y_nxt  = cy;
            ov_nxt = 1'b1;
            px_nxt = POS_W'(cx);
            py_nxt = POS_W'(cy);
            pb_nxt = btn_r;
          end
        end
        default: begin
          phase_nxt = PH_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      btn_r   <= '0;
      hdr_r   <= '0;
      dx_r    <= '0;
      x_r     <= START_POS;
      y_r     <= START_POS;
      ov_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      btn_r   <= btn_nxt;
      hdr_r   <= hdr_nxt;
      dx_r    <= dx_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    px_r <= px_nxt;
    py_r <= py_nxt;
    pb_r <= pb_nxt;
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.pos_x       = px_r;
  assign out_ch.pos_y       = py_r;
  assign out_ch.button_bits = pb_r;

  assign stat.fire  = fire;
  assign stat.phase = phase_r;
endmodule
